FILE: hdl/layer_norm_row_top_defines.svh
// assertion macros for the layer norm row block
// included by the checker module
`ifndef LAYER_NORM_ROW_TOP_DEFINES_SVH
`define LAYER_NORM_ROW_TOP_DEFINES_SVH
// implication checked on every clock, held off during reset
`define LNR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define LNR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/lnr_pkg.sv
// shared types and constants for the layer norm row block
// no dependencies
`default_nettype none
package lnr_pkg;
    typedef struct packed {
        logic signed [15:0] sample;
        logic signed [15:0] gain;
        logic signed [15:0] offset;
    } lnr_in_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               row_end;
        logic               clipped;
    } lnr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } lnr_state_t;

    typedef enum logic [1:0] {
        PASS_MEAN = 2'd0,
        PASS_VAR  = 2'd1,
        PASS_OUT  = 2'd2
    } lnr_pass_t;

    // longest row; accumulator widths are sized for it
    localparam int ROW_MAX = 1024;

    localparam logic [0:0] CFG_ROW_LENGTH = 1'b0;
    localparam logic [0:0] CFG_EPSILON    = 1'b1;
    localparam logic [23:0] INV_MAX = 24'hFFFFFF;
    localparam logic [10:0] ROW_LENGTH_RESET = 11'd1024;
    localparam logic [23:0] EPSILON_RESET = 24'd168;
endpackage
`default_nettype wire

FILE: hdl/lnr_divider.sv
// iterative restoring divider, one quotient bit per cycle
// uses no package items
`default_nettype none
module lnr_divider #(
    parameter int W = 49
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    // one shift-subtract step
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = busy_reg && (cnt_reg == CW'(1));
    assign quotient = quo_next;
endmodule
`default_nettype wire

FILE: hdl/lnr_isqrt.sv
// iterative integer square root, two radicand bits per cycle
// uses no package items
`default_nettype none
module lnr_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [49:0] radicand,
    output logic             done,
    output logic [24:0]      root
);
    logic [49:0] x_reg, x_next;
    logic [26:0] rem_reg, rem_next;
    logic [24:0] res_reg, res_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [26:0] rem_sh;
    logic [26:0] trial;

    // one digit of the root per step
    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[24:0], x_reg[49:48]};
        trial     = {res_reg, 2'b01};
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = 5'd25;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[47:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                res_next = {res_reg[23:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                res_next = {res_reg[23:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = busy_reg && (cnt_reg == 5'd1);
    assign root = res_next;
endmodule
`default_nettype wire

FILE: hdl/layer_norm_row_top.sv
// layer normalization of one row: sequencer, accumulators and output stage
// depends on lnr_pkg, lnr_divider and lnr_isqrt
//
// usage:
//   in_valid/in_ready carry one request (sample, gain, offset); each row is
//   sent three times: mean pass, variance pass, output pass.
//   out_valid/out_ready carry one result per output-pass request.
//   cfg_we/cfg_index/cfg_data write row_length (0) and epsilon (1) while idle.
// sequence:
//   mean-pass request: accepted while idle; the last of the row also runs the
//   shared divider to form the mean.
//   variance-pass request: accept, then the square on the multiplier;
//   the last one adds a divide, the 2^48 divide and the root;
//   a zero denominator skips the 2^48 divide and the root.
//   output-pass request: accept, gain product, scale product and
//   output register load; the load waits until that register is empty or
//   being drained.
// reset: registers go to row_length 1024, epsilon 168, mean pass, no result.
// stall: a stalled result stays in the output register; requests are still
//   taken until the next result needs that register, then in_ready stays low.
`default_nettype none
module layer_norm_row_top
    import lnr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire lnr_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output lnr_out_t         result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data
);
    localparam int PW = $clog2(ROW_MAX + 1);

    logic [10:0] row_length_reg;
    logic [23:0] epsilon_reg;
    lnr_state_t  state_reg, state_next;
    lnr_pass_t   pass_reg, pass_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic signed [26:0] sum_reg, sum_next;
    logic signed [15:0] mean_reg, mean_next;
    logic [42:0] sq_reg, sq_next;
    logic [23:0] inv_reg, inv_next;
    logic [1:0]  div_phase_reg, div_phase_next;
    lnr_in_t     item_reg;
    logic        last_reg;
    logic signed [33:0] prod_reg;
    logic signed [16:0] diff;
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] mul_p;
    logic        out_valid_reg;
    lnr_out_t    out_reg;
    logic [PW:0] eff_len;
    logic        last;
    logic        accept;
    logic        div_start, div_done, sq_start, sq_done;
    logic [48:0] div_a, div_b, div_q;
    logic [24:0] root;
    logic [26:0] sum_abs;
    logic [31:0] den;
    logic signed [58:0] fl;
    logic signed [43:0] r_full;
    logic        out_load;

    // effective row length
    always_comb
    begin
        if (row_length_reg == 11'd0)
            eff_len = (PW + 1)'(1);
        else if ({{(PW + 12){1'b0}}, row_length_reg} > (PW + 23)'(ROW_MAX))
            eff_len = (PW + 1)'(ROW_MAX);
        else
            eff_len = (PW + 1)'(row_length_reg);
    end
    assign last = ({1'b0, pos_reg} + 1'b1) >= eff_len;

    lnr_divider #(.W(49)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );
    lnr_isqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand({1'b0, div_q}),
        .done(sq_done), .root(root)
    );

    // shared multiplier
    assign diff  = 17'(item_reg.sample) - 17'(mean_reg);
    assign mul_p = mul_a * mul_b;
    assign sum_abs = sum_reg[26] ? 27'(-sum_reg) : 27'(sum_reg);
    assign den   = div_q[31:0] + 32'(epsilon_reg);
    assign fl    = mul_p >>> 24;
    assign r_full = 44'(fl) + 44'(item_reg.offset);

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        sq_next        = sq_reg;
        inv_next       = inv_reg;
        div_phase_next = div_phase_reg;
        div_start      = 1'b0;
        sq_start       = 1'b0;
        div_a          = '0;
        div_b          = '0;
        mul_a          = 34'(diff);
        mul_b          = 25'(diff);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pass_reg == PASS_MEAN)
                    begin
                        sum_next = sum_reg + 27'(in_data.sample);
                        if (last)
                        begin
                            pos_next   = '0;
                            state_next = ST_DIV;
                            div_phase_next = 2'd0;
                            sum_next   = sum_reg + 27'(in_data.sample);
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    else if (pass_reg == PASS_VAR)
                        state_next = ST_MUL1;
                    else
                        state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (pass_reg == PASS_VAR)
                begin
                    sq_next = sq_reg + 43'(unsigned'(mul_p[33:0]));
                    if (last_reg)
                    begin
                        pos_next   = '0;
                        state_next = ST_DIV;
                        div_phase_next = 2'd1;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mul_a      = 34'(diff);
                    mul_b      = 25'(item_reg.gain);
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                mul_a      = prod_reg;
                mul_b      = 25'({1'b0, inv_reg});
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                mul_a = prod_reg;
                mul_b = 25'({1'b0, inv_reg});
                if (out_load)
                begin
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        pos_next  = '0;
                        pass_next = PASS_MEAN;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                // phase 0 sets up mean, 1 variance; the 2^48 divide starts in ST_SQRT
                if (div_phase_reg == 2'd0)
                begin
                    div_start = 1'b1;
                    div_a = 49'(sum_abs);
                    div_b = 49'(eff_len);
                    div_phase_next = 2'd3;
                    state_next = ST_SQRT;
                    pass_next  = PASS_VAR;
                end
                else
                begin
                    div_start = 1'b1;
                    div_a = 49'(sq_reg);
                    div_b = 49'(eff_len);
                    div_phase_next = 2'd1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (div_phase_reg == 2'd3)
                begin
                    if (div_done)
                    begin
                        mean_next  = sum_reg[26] ? 16'(-div_q[26:0]) : 16'(div_q[26:0]);
                        sum_next   = '0;
                        sq_next    = '0;
                        state_next = ST_IDLE;
                    end
                end
                else if (div_phase_reg == 2'd1)
                begin
                    if (div_done)
                    begin
                        if (den == 32'd0)
                        begin
                            inv_next   = INV_MAX;
                            sq_next    = '0;
                            pass_next  = PASS_OUT;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // keep the denominator for the 2^48 divide
                            sq_next        = 43'(den);
                            div_phase_next = 2'd2;
                        end
                    end
                end
                else if (div_phase_reg == 2'd2)
                begin
                    div_start = 1'b1;
                    div_a = 49'h1_0000_0000_0000;
                    div_b = 49'(sq_reg);
                    div_phase_next = 2'd0;
                end
                else
                begin
                    if (div_done)
                        sq_start = 1'b1;
                    if (sq_done)
                    begin
                        inv_next   = root[24] ? INV_MAX : root[23:0];
                        sq_next    = '0;
                        pass_next  = PASS_OUT;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= PASS_MEAN;
            pos_reg        <= '0;
            sum_reg        <= '0;
            mean_reg       <= '0;
            sq_reg         <= '0;
            inv_reg        <= '0;
            div_phase_reg  <= '0;
            out_valid_reg  <= 1'b0;
            row_length_reg <= ROW_LENGTH_RESET;
            epsilon_reg    <= EPSILON_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            mean_reg      <= mean_next;
            sq_reg        <= sq_next;
            inv_reg       <= inv_next;
            div_phase_reg <= div_phase_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == CFG_ROW_LENGTH)
                row_length_reg <= cfg_data[10:0];
            if (cfg_we && cfg_index == CFG_EPSILON)
                epsilon_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            last_reg <= last;
        end
        if (state_reg == ST_MUL1)
            prod_reg <= mul_p[33:0];
        if (out_load)
        begin
            out_reg.row_end <= last_reg;
            if (r_full > 44'sd32767)
            begin
                out_reg.value   <= 16'sh7FFF;
                out_reg.clipped <= 1'b1;
            end
            else if (r_full < -44'sd32768)
            begin
                out_reg.value   <= -16'sh8000;
                out_reg.clipped <= 1'b1;
            end
            else
            begin
                out_reg.value   <= r_full[15:0];
                out_reg.clipped <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;
endmodule
`default_nettype wire

FILE: hdl/layer_norm_row_checker.sv
// port-level checker for the layer norm row block, bound to the top level
// depends on lnr_pkg and layer_norm_row_top_defines.svh
`default_nettype none
`include "layer_norm_row_top_defines.svh"
module layer_norm_row_checker
    import lnr_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire lnr_out_t result
);
    // a new result never shows up right after a request is taken
    `LNR_ASSERT_NXT(a_no_rise_after_req, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
    // a stalled result holds its payload
    `LNR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(result))
    // a clipped value sits at a rail
    `LNR_ASSERT_IMP(a_clip_rail, clk, rst_n, out_valid && result.clipped,
        result.value == 16'sh7FFF || result.value == -16'sh8000)
endmodule

bind layer_norm_row_top layer_norm_row_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .result(result)
);
`default_nettype wire
